// File: sv/hsvrgb_pkg.sv
package hsvrgb_pkg;

   localparam int unsigned FULL_SCALE  = 255;
   localparam int unsigned DEG_SECTOR  = 60;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      SECT_0    = 3'd0,
      SECT_1    = 3'd1,
      SECT_2    = 3'd2,
      SECT_3    = 3'd3,
      SECT_4    = 3'd4,
      SECT_5    = 3'd5,
      SECT_NONE = 3'd6
   } sector_type;

   typedef struct packed {
      logic [15:0] chroma_prod;
      sector_type  sector;
      logic [7:0]  weight;
      logic [7:0]  value_level;
   } entry_type;

   // Exact floor(x/255) for x up to 255*255: (x + 1 + (x >> 8)) >> 8
   function automatic logic [7:0] div_full_scale(input logic [15:0] x);
      logic [16:0] sum;
      sum = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return sum[15:8];
   endfunction

endpackage

// File: sv/hsvrgb_front.sv
module hsvrgb_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [8:0]             req_hue,
   input  logic [7:0]             req_saturation,
   input  logic [7:0]             req_value_level,
   input  logic                   q_full,
   output logic                   push,
   output hsvrgb_pkg::entry_type  push_data
);

   logic       stage_vld_ff, stage_vld_in;
   logic [8:0] hue_ff;
   logic [7:0] sat_ff;
   logic [7:0] val_ff;
   logic       take;

   hsvrgb_pkg::sector_type sector;
   logic [13:0] hue_x17;
   logic [11:0] hp;
   logic [11:0] base;
   logic [11:0] pos;
   logic        odd;

   assign push         = stage_vld_ff && !q_full;
   assign busy         = stage_vld_ff && q_full;
   assign take         = start && !busy;
   assign stage_vld_in = take || (stage_vld_ff && !push);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         hue_ff <= req_hue;
         sat_ff <= req_saturation;
         val_ff <= req_value_level;
      end
   end

   // Sector is floor(hue/60), which equals floor(hp/255), for hues below 360; higher hues give SECT_NONE
   always_comb begin
      if (hue_ff < 9'(1 * hsvrgb_pkg::DEG_SECTOR)) begin
         sector = hsvrgb_pkg::SECT_0;
      end else if (hue_ff < 9'(2 * hsvrgb_pkg::DEG_SECTOR)) begin
         sector = hsvrgb_pkg::SECT_1;
      end else if (hue_ff < 9'(3 * hsvrgb_pkg::DEG_SECTOR)) begin
         sector = hsvrgb_pkg::SECT_2;
      end else if (hue_ff < 9'(4 * hsvrgb_pkg::DEG_SECTOR)) begin
         sector = hsvrgb_pkg::SECT_3;
      end else if (hue_ff < 9'(5 * hsvrgb_pkg::DEG_SECTOR)) begin
         sector = hsvrgb_pkg::SECT_4;
      end else if (hue_ff < 9'(6 * hsvrgb_pkg::DEG_SECTOR)) begin
         sector = hsvrgb_pkg::SECT_5;
      end else begin
         sector = hsvrgb_pkg::SECT_NONE;
      end
   end

   always_comb begin
      unique case (sector)
         hsvrgb_pkg::SECT_0: base = 12'd0;
         hsvrgb_pkg::SECT_1: base = 12'(1 * hsvrgb_pkg::FULL_SCALE);
         hsvrgb_pkg::SECT_2: base = 12'(2 * hsvrgb_pkg::FULL_SCALE);
         hsvrgb_pkg::SECT_3: base = 12'(3 * hsvrgb_pkg::FULL_SCALE);
         hsvrgb_pkg::SECT_4: base = 12'(4 * hsvrgb_pkg::FULL_SCALE);
         hsvrgb_pkg::SECT_5: base = 12'(5 * hsvrgb_pkg::FULL_SCALE);
         default:            base = 12'd0;
      endcase
   end

   // hp = floor(255*hue/60) = floor(17*hue/4)
   assign hue_x17 = {1'b0, hue_ff, 4'd0} + {5'd0, hue_ff};
   assign hp      = hue_x17[13:2];
   assign pos     = hp - base;
   assign odd     = (sector == hsvrgb_pkg::SECT_1) || (sector == hsvrgb_pkg::SECT_3) ||
                    (sector == hsvrgb_pkg::SECT_5);

   // Weight of X is 255 - |hp mod 510 - 255|: rising in even sectors, falling in odd
   always_comb begin
      push_data.chroma_prod = 16'(sat_ff * val_ff);
      push_data.sector      = sector;
      push_data.weight      = odd ? (8'(hsvrgb_pkg::FULL_SCALE) - pos[7:0]) : pos[7:0];
      push_data.value_level = val_ff;
   end

endmodule

// File: sv/hsvrgb_queue.sv
module hsvrgb_queue #(
   parameter int unsigned DEPTH = hsvrgb_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hsvrgb_pkg::entry_type  push_data,
   output logic                   full,
   output logic                   pop_vld,
   output hsvrgb_pkg::entry_type  pop_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   hsvrgb_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign pop_vld  = (count_ff != '0);
   // The back end never stalls: drain every cycle
   assign pop      = pop_vld;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/hsvrgb_back.sv
module hsvrgb_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_vld,
   input  hsvrgb_pkg::entry_type  in_data,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_red,
   output logic [7:0]             rsp_green,
   output logic [7:0]             rsp_blue
);

   // Stage 1: chroma
   logic                   s1_vld_ff;
   logic [7:0]             s1_chroma_ff;
   logic [7:0]             s1_weight_ff;
   logic [7:0]             s1_value_ff;
   hsvrgb_pkg::sector_type s1_sector_ff;

   // Stage 2: chroma * weight, offset
   logic                   s2_vld_ff;
   logic [15:0]            s2_xprod_ff;
   logic [7:0]             s2_chroma_ff;
   logic [7:0]             s2_offset_ff;
   hsvrgb_pkg::sector_type s2_sector_ff;

   // Stage 3: result
   logic                   rsp_vld_ff;
   logic [7:0]             red_ff, red_in;
   logic [7:0]             green_ff, green_in;
   logic [7:0]             blue_ff, blue_in;
   logic [7:0]             x_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= in_vld;
         s2_vld_ff  <= s1_vld_ff;
         rsp_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_chroma_ff <= hsvrgb_pkg::div_full_scale(in_data.chroma_prod);
      s1_weight_ff <= in_data.weight;
      s1_value_ff  <= in_data.value_level;
      s1_sector_ff <= in_data.sector;

      s2_xprod_ff  <= 16'(s1_chroma_ff * s1_weight_ff);
      s2_chroma_ff <= s1_chroma_ff;
      s2_offset_ff <= s1_value_ff - s1_chroma_ff;
      s2_sector_ff <= s1_sector_ff;

      red_ff       <= red_in;
      green_ff     <= green_in;
      blue_ff      <= blue_in;
   end

   assign x_val = hsvrgb_pkg::div_full_scale(s2_xprod_ff);

   // Place chroma and X by sector, then lift every channel by the offset
   always_comb begin
      red_in   = s2_offset_ff;
      green_in = s2_offset_ff;
      blue_in  = s2_offset_ff;
      unique case (s2_sector_ff)
         hsvrgb_pkg::SECT_0: begin
            red_in   = s2_offset_ff + s2_chroma_ff;
            green_in = s2_offset_ff + x_val;
         end
         hsvrgb_pkg::SECT_1: begin
            red_in   = s2_offset_ff + x_val;
            green_in = s2_offset_ff + s2_chroma_ff;
         end
         hsvrgb_pkg::SECT_2: begin
            green_in = s2_offset_ff + s2_chroma_ff;
            blue_in  = s2_offset_ff + x_val;
         end
         hsvrgb_pkg::SECT_3: begin
            green_in = s2_offset_ff + x_val;
            blue_in  = s2_offset_ff + s2_chroma_ff;
         end
         hsvrgb_pkg::SECT_4: begin
            red_in   = s2_offset_ff + x_val;
            blue_in  = s2_offset_ff + s2_chroma_ff;
         end
         hsvrgb_pkg::SECT_5: begin
            red_in   = s2_offset_ff + s2_chroma_ff;
            blue_in  = s2_offset_ff + x_val;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

// File: sv/hsv_to_rgb_integer.sv
// HSV to RGB converter, one pixel per clock. Raise start with hue (degrees),
// saturation and value; the pixel is taken at any edge where start is high and
// busy is low. The result appears on rsp_red/green/blue with rsp_valid high for
// a single cycle, after passing the pipeline, in order; the receiver cannot
// hold it, so capture it when rsp_valid is seen. The pipeline (input register,
// two-entry queue, three stages for chroma, X and the channel sums) drains every
// cycle, so busy stays low and a new pixel may be given on every clock.
// Hues of 360 and above give all three channels equal to value minus chroma.
module hsv_to_rgb_integer #(
   parameter int unsigned QUEUE_DEPTH = hsvrgb_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [8:0] req_hue,
   input  logic [7:0] req_saturation,
   input  logic [7:0] req_value_level,
   output logic       rsp_valid,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue
);

   logic                  q_full;
   logic                  push;
   hsvrgb_pkg::entry_type push_data;
   logic                  pop_vld;
   hsvrgb_pkg::entry_type pop_data;

   hsvrgb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_hue         (req_hue),
      .req_saturation  (req_saturation),
      .req_value_level (req_value_level),
      .q_full          (q_full),
      .push            (push),
      .push_data       (push_data)
   );

   hsvrgb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop_vld   (pop_vld),
      .pop_data  (pop_data)
   );

   hsvrgb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (pop_vld),
      .in_data   (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_red   (rsp_red),
      .rsp_green (rsp_green),
      .rsp_blue  (rsp_blue)
   );

endmodule
